// ===== rtl/csc_pkg.sv =====
// Shared types, constants and elaboration-time table functions for the CORDIC sine/cosine unit.
`default_nettype none

package csc_pkg;

    typedef logic [63:0] t_word;

    typedef struct packed {
        logic       valid;
        logic [1:0] quad;
        logic       zero;
    } t_ctl;

    localparam int    IN_BITS  = 31;
    localparam int    IN_FRAC  = 28;
    localparam int    OUT_BITS = 30;
    localparam t_word PI_Q60   = 64'h3243_F6A8_885A_308D;
    localparam t_word K_NUM    = 64'd60725293510314;
    localparam t_word K_DEN    = 64'd100000000000000;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    // Round half up, then drop s bits.
    function automatic t_word f_round_shr(input t_word v, input int s);
        if (s <= 0) begin
            return v;
        end
        return (v + (t_word'(1) << (s - 1))) >> s;
    endfunction

    // Restoring long division, elaboration only.
    function automatic t_word f_udiv(input t_word num, input t_word den);
        t_word rem;
        t_word quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // arctan(2^-idx) from the truncated odd series, at frac fraction bits.
    function automatic t_word f_atan(input int idx, input int frac);
        t_word sum;
        t_word term;
        int    e;
        sum = '0;
        if (idx == 0) begin
            return f_round_shr(PI_Q60, 62 - frac);
        end
        for (int k = 0; k < 32; k++) begin
            e = idx * (2 * k + 1);
            if (e < 64) begin
                term = f_udiv(t_word'(1) << (64 - e), t_word'(2 * k + 1));
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return f_round_shr((sum + 64'd2) >> 2, 62 - frac);
    endfunction

    // CORDIC gain K rounded to nearest at frac bits.
    function automatic t_word f_k_init(input int frac);
        t_word r;
        t_word q;
        r = K_NUM;
        q = '0;
        for (int b = 0; b < frac; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= K_DEN) begin
                r    = r - K_DEN;
                q[0] = 1'b1;
            end
        end
        if ((r << 1) >= K_DEN) begin
            q = q + 64'd1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/csc_fold.sv =====
// Input stage: scales the angle and folds it into the first quadrant.
`default_nettype none

module csc_fold #(
    parameter int FRAC_BITS = 28
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic [csc_pkg::IN_BITS-1:0]     i_angle,
    output csc_pkg::t_ctl                        o_ctl,
    output csc_pkg::t_word                       o_target
);
    import csc_pkg::*;

    localparam int    SHL        = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
    localparam int    SHR        = (FRAC_BITS >= IN_FRAC) ? 0 : IN_FRAC - FRAC_BITS;
    localparam t_word HALF_PI    = f_round_shr(PI_Q60, 61 - FRAC_BITS);
    localparam t_word FULL_PI    = f_round_shr(PI_Q60, 60 - FRAC_BITS);
    localparam t_word THREE_HALF = f_round_shr(PI_Q60 + (PI_Q60 << 1), 61 - FRAC_BITS);

    t_word      w_scaled;
    t_word      w_offset;
    logic [1:0] w_quad;
    t_ctl       n_ctl;
    t_word      n_target;
    t_ctl       r_ctl;
    t_word      r_target;

    always_comb begin
        w_scaled = (t_word'(i_angle) << SHL) >> SHR;
        if (w_scaled < HALF_PI) begin
            w_quad   = QUAD_I;
            w_offset = '0;
        end else if (w_scaled < FULL_PI) begin
            w_quad   = QUAD_II;
            w_offset = HALF_PI;
        end else if (w_scaled < THREE_HALF) begin
            w_quad   = QUAD_III;
            w_offset = FULL_PI;
        end else begin
            w_quad   = QUAD_IV;
            w_offset = THREE_HALF;
        end
        n_target    = w_scaled - w_offset;
        n_ctl.valid = i_valid;
        n_ctl.quad  = w_quad;
        n_ctl.zero  = (n_target == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_target <= n_target;
    end

    assign o_ctl    = r_ctl;
    assign o_target = r_target;

endmodule

`default_nettype wire

// ===== rtl/csc_stage.sv =====
// One registered CORDIC micro-rotation.
`default_nettype none

module csc_stage #(
    parameter int STAGE     = 0,
    parameter int FRAC_BITS = 28
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire csc_pkg::t_ctl   i_ctl,
    input  wire csc_pkg::t_word  i_x,
    input  wire csc_pkg::t_word  i_y,
    input  wire csc_pkg::t_word  i_z,
    input  wire csc_pkg::t_word  i_target,
    output csc_pkg::t_ctl        o_ctl,
    output csc_pkg::t_word       o_x,
    output csc_pkg::t_word       o_y,
    output csc_pkg::t_word       o_z,
    output csc_pkg::t_word       o_target
);
    import csc_pkg::*;

    localparam t_word ATAN = f_atan(STAGE, FRAC_BITS);

    t_word w_xs;
    t_word w_ys;
    t_word n_x;
    t_word n_y;
    t_word n_z;
    t_ctl  r_ctl;
    t_word r_x;
    t_word r_y;
    t_word r_z;
    t_word r_target;

    always_comb begin
        w_xs = t_word'($signed(i_x) >>> STAGE);
        w_ys = t_word'($signed(i_y) >>> STAGE);
        // ties turn negative
        if ($signed(i_target) > $signed(i_z)) begin
            n_x = i_x - w_ys;
            n_y = w_xs + i_y;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_target <= i_target;
    end

    assign o_ctl    = r_ctl;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_z      = r_z;
    assign o_target = r_target;

endmodule

`default_nettype wire

// ===== rtl/csc_out.sv =====
// Output stages: quadrant unfold, then rounding and saturation to Q2.28.
`default_nettype none

module csc_out #(
    parameter int FRAC_BITS = 28
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire csc_pkg::t_ctl                       i_ctl,
    input  wire csc_pkg::t_word                      i_x,
    input  wire csc_pkg::t_word                      i_y,
    output logic                                     o_strobe,
    output logic signed [csc_pkg::OUT_BITS-1:0]      o_sine,
    output logic signed [csc_pkg::OUT_BITS-1:0]      o_cosine
);
    import csc_pkg::*;

    localparam int    RND_SH   = (FRAC_BITS > IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
    localparam int    LSH      = (FRAC_BITS > IN_FRAC) ? 0 : IN_FRAC - FRAC_BITS;
    localparam t_word RND_HALF = (RND_SH > 0) ? (t_word'(1) << ((RND_SH > 0) ? RND_SH - 1 : 0))
                                              : '0;
    localparam t_word ONE      = t_word'(1) << FRAC_BITS;
    localparam t_word SAT_HI   = (t_word'(1) << (OUT_BITS - 1)) - 64'd1;
    localparam t_word SAT_LO   = ~SAT_HI;

    function automatic logic [OUT_BITS-1:0] f_to_out(input t_word v);
        t_word r;
        t_word sum;
        sum = v + RND_HALF;
        if (FRAC_BITS > IN_FRAC) begin
            r = t_word'($signed(sum) >>> RND_SH);
            if ($signed(v) > 0 && $signed(r) < 0) begin
                r = SAT_HI;
            end
        end else begin
            if ($signed(v) > ($signed(SAT_HI) >>> LSH)) begin
                r = SAT_HI;
            end else if ($signed(v) < ($signed(SAT_LO) >>> LSH)) begin
                r = SAT_LO;
            end else begin
                r = v << LSH;
            end
        end
        if ($signed(r) > $signed(SAT_HI)) begin
            r = SAT_HI;
        end
        if ($signed(r) < $signed(SAT_LO)) begin
            r = SAT_LO;
        end
        return r[OUT_BITS-1:0];
    endfunction

    t_word               w_sn;
    t_word               w_cs;
    t_word               n_s;
    t_word               n_c;
    logic                r_valid;
    t_word               r_s;
    t_word               r_c;
    logic                r_strobe;
    logic [OUT_BITS-1:0] r_sine;
    logic [OUT_BITS-1:0] r_cosine;

    always_comb begin
        w_sn = i_ctl.zero ? '0  : i_y;
        w_cs = i_ctl.zero ? ONE : i_x;
        case (i_ctl.quad)
            QUAD_I: begin
                n_s = w_sn;
                n_c = w_cs;
            end
            QUAD_II: begin
                n_s = w_cs;
                n_c = '0 - w_sn;
            end
            QUAD_III: begin
                n_s = '0 - w_sn;
                n_c = '0 - w_cs;
            end
            default: begin
                n_s = '0 - w_cs;
                n_c = w_sn;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_valid  <= i_ctl.valid;
            r_strobe <= r_valid;
        end
        r_s      <= n_s;
        r_c      <= n_c;
        r_sine   <= f_to_out(r_s);
        r_cosine <= f_to_out(r_c);
    end

    assign o_strobe = r_strobe;
    assign o_sine   = $signed(r_sine);
    assign o_cosine = $signed(r_cosine);

endmodule

`default_nettype wire

// ===== rtl/cordic_sine_cosine_unit.sv =====
// Top level of the pipelined rotation-mode CORDIC sine/cosine unit.
//
// Usage:
//   Request channel: drive i_angle (unsigned Q3.28 radians, below 2*pi) and
//   raise start. The request is taken at a rising edge where start is high
//   and busy is low. busy is only high while reset is applied and in the
//   cycle after it, so a new request can be issued every cycle.
//   Result channel: o_sine and o_cosine (signed Q2.28) are valid for exactly
//   one cycle, marked by o_strobe. There is no backpressure; the receiver
//   must take every result in the cycle it appears.
//   Pipeline from request to strobe: one fold stage, one register per CORDIC
//   iteration, quadrant unfold, round/saturate.
//   Throughput: one request per cycle; every stage is fully registered and
//   each iteration has its own adder set and arctan constant.
//   Results come out in request order.
//   Reset (synchronous, active low) clears all pipeline valid bits; any
//   requests in flight are dropped. The arctan table and gain are constants.
`default_nettype none

module cordic_sine_cosine_unit #(
    parameter int ITERATIONS = 32,
    parameter int FRAC_BITS  = 28
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire logic [csc_pkg::IN_BITS-1:0]         i_angle,
    output logic                                     busy,
    output logic                                     o_strobe,
    output logic signed [csc_pkg::OUT_BITS-1:0]      o_sine,
    output logic signed [csc_pkg::OUT_BITS-1:0]      o_cosine
);
    import csc_pkg::*;

    localparam t_word K_INIT  = f_k_init(FRAC_BITS);
    localparam int    LATENCY = ITERATIONS + 3;

    logic  r_busy;
    logic  w_accept;
    t_ctl  w_ctl    [0:ITERATIONS];
    t_word w_x      [0:ITERATIONS];
    t_word w_y      [0:ITERATIONS];
    t_word w_z      [0:ITERATIONS];
    t_word w_target [0:ITERATIONS];

    // Hold off requests during reset and the cycle after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy | ~i_rst_n;
    assign w_accept = start & ~busy;

    csc_fold #(
        .FRAC_BITS (FRAC_BITS)
    ) u_fold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_angle  (i_angle),
        .o_ctl    (w_ctl[0]),
        .o_target (w_target[0])
    );

    // Vector starts at (K, 0) with zero accumulated angle.
    assign w_x[0] = K_INIT;
    assign w_y[0] = '0;
    assign w_z[0] = '0;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
        csc_stage #(
            .STAGE     (g),
            .FRAC_BITS (FRAC_BITS)
        ) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[g]),
            .i_x      (w_x[g]),
            .i_y      (w_y[g]),
            .i_z      (w_z[g]),
            .i_target (w_target[g]),
            .o_ctl    (w_ctl[g+1]),
            .o_x      (w_x[g+1]),
            .o_y      (w_y[g+1]),
            .o_z      (w_z[g+1]),
            .o_target (w_target[g+1])
        );
    end

    // The final angle accumulator and target are not needed past this point.
    csc_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl[ITERATIONS]),
        .i_x      (w_x[ITERATIONS]),
        .i_y      (w_y[ITERATIONS]),
        .o_strobe (o_strobe),
        .o_sine   (o_sine),
        .o_cosine (o_cosine)
    );

    // Every strobe traces back to an accepted request at the pipeline input.
    a_strobe_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, LATENCY))
        else $error("result strobe without matching request");

    // A valid bit at the end of the CORDIC chain always has a matching valid bit at its entry.
    a_chain_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[ITERATIONS].valid |-> $past(w_ctl[0].valid, ITERATIONS))
        else $error("CORDIC chain valid out of step");

    // A zero angle must come out as sine 0, cosine 1.0.
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(w_accept && (i_angle == '0), LATENCY)) |->
            (o_sine == '0 && o_cosine == OUT_BITS'(1 << IN_FRAC)))
        else $error("zero angle did not give sine 0, cosine 1");

    // No fold-stage entry without an accepted request.
    a_fold_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[0].valid |-> $past(w_accept))
        else $error("fold stage valid without request");

endmodule

`default_nettype wire
